@@ rtl/diff_drive_odometry_core_macros.svh @@
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent assertion shorthands for the odometry core.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DDO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// Odometry package
// Types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int RATE_W = 16;
    localparam int ANG_W = 16;
    localparam int ENC_W = 24;
    localparam int DT_W = 20;
    localparam int IDX_W = 1;

    localparam logic [IDX_W-1:0] REG_WHEEL_RADIUS = 1'b0;
    localparam logic [IDX_W-1:0] REG_INVERSE_TRACK = 1'b1;

    localparam logic ACT_SENSOR = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [15:0] WHEEL_RADIUS_RST = 16'd2949;
    localparam logic [15:0] INVERSE_TRACK_RST = 16'd7447;

    localparam int DEG2RAD_Q16 = 1143;
    localparam int US_TO_S_Q40 = 1099512;
    localparam int TWO_PI_Q13 = 51472;
    localparam int PI_Q13 = 25736;
    localparam int HALF_PI_Q13 = 12868;
    localparam int WRAP_PI_Q13 = 25723;
    localparam int WRAP_TWO_PI_Q13 = 51446;
    localparam int CORDIC_GAIN = 39797;
    localparam int CORDIC_STEPS = 16;

    typedef struct packed {
        logic       start;
        logic [1:0] sel;
    } mul_ctl_t;

    function automatic logic [17:0] atan_q16(input logic [3:0] i);
        logic [17:0] v;
        begin
            case (i)
                4'd0:    v = 18'd51472;
                4'd1:    v = 18'd30386;
                4'd2:    v = 18'd16055;
                4'd3:    v = 18'd8150;
                4'd4:    v = 18'd4091;
                4'd5:    v = 18'd2047;
                4'd6:    v = 18'd1024;
                4'd7:    v = 18'd512;
                4'd8:    v = 18'd256;
                4'd9:    v = 18'd128;
                4'd10:   v = 18'd64;
                4'd11:   v = 18'd32;
                4'd12:   v = 18'd16;
                4'd13:   v = 18'd8;
                4'd14:   v = 18'd4;
                default: v = 18'd2;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/ddo_if.sv @@
// ----------------------------------------------------------------------------
// Odometry channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    logic signed [15:0] heading_deg;
    logic [19:0] elapsed_us;
    modport source(output valid, action, left_rate, right_rate, heading_deg, elapsed_us,
                   input ready);
    modport sink(input valid, action, left_rate, right_rate, heading_deg, elapsed_us,
                 output ready);
endinterface

interface ddo_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
    modport source(output valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                   input ready);
    modport sink(input valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                 output ready);
endinterface

interface ddo_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/ddo_serial_mul.sv @@
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_serial_mul #(
    parameter int AW = 48,
    parameter int BW = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic                     done,
    output logic signed [AW+BW-1:0]  p
);
    localparam int CW = $clog2(BW + 1);

    logic [CW-1:0]            cnt_reg;
    logic                     busy_reg;
    logic signed [AW+BW-1:0]  acc_reg;
    logic signed [AW+BW-1:0]  mcand_reg;
    logic [BW-1:0]            mplier_reg;
    logic                     done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // two's complement: top bit of multiplier carries negative weight
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= (AW+BW)'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                if (cnt_reg == CW'(BW - 1))
                    acc_reg <= acc_reg - mcand_reg;
                else
                    acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule

@@ rtl/ddo_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Range reduction then 16 rotation steps, one per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [23:0]  angle,
    output logic                done,
    output logic signed [19:0]  cos_out,
    output logic signed [19:0]  sin_out
);
    typedef enum logic [1:0] {C_IDLE, C_RED, C_ROT} cst_t;

    cst_t               st_reg;
    logic [3:0]         i_reg;
    logic signed [23:0] r_reg;
    logic               neg_reg;
    logic signed [19:0] x_reg, y_reg;
    logic signed [20:0] z_reg;
    logic               done_reg;

    logic signed [23:0] r_mod;
    logic signed [23:0] r1;
    logic signed [23:0] r2;
    logic               n2;
    logic signed [19:0] xs, ys;
    logic signed [20:0] at;

    // C-style remainder keeps the sign of the dividend; |angle| <= 2^23 so a
    // few conditional subtracts are too few: use one compare loop over cycles
    always_comb
    begin
        r_mod = r_reg;
        r1 = r_mod;
        if (r1 > 24'sd25736)
            r1 = r1 - 24'sd51472;
        if (r1 < -24'sd25736)
            r1 = r1 + 24'sd51472;
        r2 = r1;
        n2 = 1'b0;
        if (r1 > 24'sd12868)
        begin
            r2 = r1 - 24'sd25736;
            n2 = 1'b1;
        end
        else if (r1 < -24'sd12868)
        begin
            r2 = r1 + 24'sd25736;
            n2 = 1'b1;
        end
        xs = y_reg >>> i_reg;
        ys = x_reg >>> i_reg;
        at = 21'(signed'({1'b0, ddo_pkg::atan_q16(i_reg)}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= C_IDLE;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        r_reg  <= angle;
                        st_reg <= C_RED;
                    end
                end
                C_RED:
                begin
                    // subtract 2*pi one step a cycle toward zero
                    if (r_reg >= 24'sd51472)
                        r_reg <= r_reg - 24'sd51472;
                    else if (r_reg <= -24'sd51472)
                        r_reg <= r_reg + 24'sd51472;
                    else
                    begin
                        neg_reg <= n2;
                        z_reg   <= 21'(r2) <<< 3;
                        x_reg   <= 20'sd39797;
                        y_reg   <= '0;
                        i_reg   <= '0;
                        st_reg  <= C_ROT;
                    end
                end
                C_ROT:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - xs;
                        y_reg <= y_reg + ys;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + xs;
                        y_reg <= y_reg - ys;
                        z_reg <= z_reg + at;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == 4'(ddo_pkg::CORDIC_STEPS - 1))
                    begin
                        st_reg   <= C_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                default: st_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;
endmodule

@@ rtl/diff_drive_odometry_core.sv @@
// ----------------------------------------------------------------------------
// Differential drive odometry core
// Dead-reckoning pose integration from wheel rates and heading samples.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  in_ch     in   action, left_rate, right_rate, heading_deg, elapsed_us
//  out_ch    out  pos_x, pos_y, heading, linear_speed, turn_rate
//  cfg_ch    in   index (0 radius, 1 inverse track), data
//
//  Sensor beats run one 48-bit serial multiply (one multiplier bit per
//  cycle) to convert the heading. Tick beats run twelve serial multiplies
//  and two CORDIC passes; each pass first strips whole multiples of 2*pi
//  from its angle.
//  Reset clears the control and pose state, config registers go to their defaults.
//  A finished result waits in the output register; a new beat is taken
//  only after it has been delivered.
`include "diff_drive_odometry_core_macros.svh"
module diff_drive_odometry_core #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    ddo_in_if.sink  in_ch,
    ddo_out_if.source out_ch,
    ddo_cfg_if.sink cfg_ch
);
    localparam int PW = POSITION_WIDTH;
    localparam int MW = 48;

    typedef enum logic [4:0] {
        S_IDLE, S_SENS, S_V, S_W1, S_W2, S_DT, S_STEP, S_TURN,
        S_COR1, S_DX, S_DY, S_COR2, S_P1, S_P2, S_P3, S_P4, S_FUSE, S_OUT
    } st_t;

    st_t st_reg;
    logic [15:0] radius_reg, itrack_reg;
    logic signed [15:0] left_reg, right_reg, shead_reg, fused_reg;
    logic signed [23:0] enc_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic [19:0] el_reg;
    logic signed [15:0] vd_reg, wd_reg;
    logic signed [MW-1:0] dxy_reg, dx_reg, dy_reg, acc_reg;
    logic signed [MW-1:0] dt_reg;
    logic signed [23:0] dth_reg;
    logic signed [19:0] cd_reg, sd_reg;
    logic out_valid_reg;
    logic mstart_reg, cstart_reg;
    logic signed [MW-1:0] ma_reg, mb_reg;
    logic signed [23:0] cang_reg;

    logic mdone, cdone;
    logic signed [2*MW-1:0] mp;
    logic signed [19:0] ccos, csin;

    ddo_serial_mul #(.AW(MW), .BW(MW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mstart_reg), .a(ma_reg), .b(mb_reg),
        .done(mdone), .p(mp)
    );

    ddo_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cstart_reg), .angle(cang_reg),
        .done(cdone), .cos_out(ccos), .sin_out(csin)
    );

    function automatic logic signed [MW-1:0] rnd(input logic signed [2*MW-1:0] v,
                                                  input int s);
        logic signed [2*MW-1:0] t;
        begin
            t = (v + ((2*MW)'(1) <<< (s - 1))) >>> s;
            return MW'(t);
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [MW-1:0] v);
        begin
            if (v > MW'(32767))
                return 16'sd32767;
            if (v < -MW'(32768))
                return -16'sd32768;
            return 16'(v);
        end
    endfunction

    function automatic logic signed [PW-1:0] satp(input logic signed [MW:0] v);
        logic signed [MW:0] hi;
        logic signed [MW:0] lo;
        begin
            hi = ((MW+1)'(1) <<< (PW - 1)) - (MW+1)'(1);
            lo = -hi - (MW+1)'(1);
            if (v > hi)
                return {1'b0, {(PW-1){1'b1}}};
            if (v < lo)
                return {1'b1, {(PW-1){1'b0}}};
            return PW'(v);
        end
    endfunction

    // turn for this tick, rounded and clamped to the encoder width
    logic signed [MW-1:0] turn_full;
    logic signed [23:0]   turn_sat;

    always_comb
    begin
        turn_full = rnd(mp, 35);
        if (turn_full > MW'(8388607))
            turn_sat = 24'sd8388607;
        else if (turn_full < -MW'(8388608))
            turn_sat = 24'sh800000;
        else
            turn_sat = 24'(turn_full);
    end

    logic signed [24:0] enc_sum;
    logic signed [24:0] f0, f1, f2;

    always_comb
    begin
        enc_sum = 25'(enc_reg) + 25'(dth_reg);
        if (enc_sum > 25'sd8388607)
            enc_sum = 25'sd8388607;
        if (enc_sum < -25'sd8388608)
            enc_sum = -25'sd8388608;
        f0 = (25'(shead_reg) + enc_sum) >>> 1;
        f1 = f0;
        if (f1 >= 25'sd25723)
            f1 = f1 - 25'sd51446;
        f2 = f1;
        if (f2 <= -25'sd25723)
            f2 = f2 + 25'sd51446;
        if (f2 > 25'sd25723)
            f2 = 25'sd25723;
        if (f2 < -25'sd25723)
            f2 = -25'sd25723;
    end

    assign in_ch.ready  = (st_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            radius_reg    <= ddo_pkg::WHEEL_RADIUS_RST;
            itrack_reg    <= ddo_pkg::INVERSE_TRACK_RST;
            left_reg      <= '0;
            right_reg     <= '0;
            shead_reg     <= '0;
            fused_reg     <= '0;
            enc_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            out_valid_reg <= 1'b0;
            mstart_reg    <= 1'b0;
            cstart_reg    <= 1'b0;
        end
        else
        begin
            mstart_reg <= 1'b0;
            cstart_reg <= 1'b0;
            if (cfg_ch.valid)
            begin
                case (cfg_ch.index)
                    ddo_pkg::REG_WHEEL_RADIUS:  radius_reg <= cfg_ch.data;
                    ddo_pkg::REG_INVERSE_TRACK: itrack_reg <= cfg_ch.data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && !out_valid_reg)
                    begin
                        if (in_ch.action == ddo_pkg::ACT_SENSOR)
                        begin
                            left_reg   <= in_ch.left_rate;
                            right_reg  <= in_ch.right_rate;
                            ma_reg     <= MW'(in_ch.heading_deg);
                            mb_reg     <= MW'(ddo_pkg::DEG2RAD_Q16);
                            mstart_reg <= 1'b1;
                            st_reg     <= S_SENS;
                        end
                        else
                        begin
                            el_reg     <= in_ch.elapsed_us;
                            ma_reg     <= MW'($signed({1'b0, radius_reg}));
                            mb_reg     <= MW'(left_reg) + MW'(right_reg);
                            mstart_reg <= 1'b1;
                            st_reg     <= S_V;
                        end
                    end
                end
                S_SENS:
                    if (mdone)
                    begin
                        shead_reg <= sat16(rnd(mp, 9));
                        st_reg    <= S_IDLE;
                    end
                S_V:
                    if (mdone)
                    begin
                        vd_reg     <= sat16(rnd(mp, 17));
                        ma_reg     <= MW'($signed({1'b0, radius_reg}));
                        mb_reg     <= MW'(left_reg) - MW'(right_reg);
                        mstart_reg <= 1'b1;
                        st_reg     <= S_W1;
                    end
                S_W1:
                    if (mdone)
                    begin
                        ma_reg     <= MW'(mp);
                        mb_reg     <= MW'($signed({1'b0, itrack_reg}));
                        mstart_reg <= 1'b1;
                        st_reg     <= S_W2;
                    end
                S_W2:
                    if (mdone)
                    begin
                        wd_reg     <= sat16(rnd(mp, 28));
                        ma_reg     <= MW'($signed({1'b0, el_reg}));
                        mb_reg     <= MW'(ddo_pkg::US_TO_S_Q40);
                        mstart_reg <= 1'b1;
                        st_reg     <= S_DT;
                    end
                S_DT:
                    if (mdone)
                    begin
                        dt_reg     <= MW'(mp);
                        ma_reg     <= MW'(vd_reg);
                        mb_reg     <= MW'(mp);
                        mstart_reg <= 1'b1;
                        st_reg     <= S_STEP;
                    end
                S_STEP:
                    if (mdone)
                    begin
                        dxy_reg    <= rnd(mp, 32);
                        ma_reg     <= MW'(wd_reg);
                        mb_reg     <= dt_reg;
                        mstart_reg <= 1'b1;
                        st_reg     <= S_TURN;
                    end
                S_TURN:
                    if (mdone)
                    begin
                        dth_reg    <= turn_sat;
                        cang_reg   <= turn_sat;
                        cstart_reg <= 1'b1;
                        st_reg     <= S_COR1;
                    end
                S_COR1:
                    if (cdone)
                    begin
                        sd_reg     <= csin;
                        ma_reg     <= MW'(ccos);
                        mb_reg     <= dxy_reg;
                        mstart_reg <= 1'b1;
                        st_reg     <= S_DX;
                    end
                S_DX:
                    if (mdone)
                    begin
                        dx_reg     <= rnd(mp, 16);
                        ma_reg     <= MW'(sd_reg);
                        mb_reg     <= dxy_reg;
                        mstart_reg <= 1'b1;
                        st_reg     <= S_DY;
                    end
                S_DY:
                    if (mdone)
                    begin
                        dy_reg     <= -rnd(mp, 16);
                        cang_reg   <= 24'(fused_reg);
                        cstart_reg <= 1'b1;
                        st_reg     <= S_COR2;
                    end
                S_COR2:
                    if (cdone)
                    begin
                        cd_reg     <= ccos;
                        sd_reg     <= csin;
                        ma_reg     <= MW'(ccos);
                        mb_reg     <= dx_reg;
                        mstart_reg <= 1'b1;
                        st_reg     <= S_P1;
                    end
                S_P1:
                    if (mdone)
                    begin
                        acc_reg    <= MW'(mp);
                        ma_reg     <= MW'(sd_reg);
                        mb_reg     <= dy_reg;
                        mstart_reg <= 1'b1;
                        st_reg     <= S_P2;
                    end
                S_P2:
                    if (mdone)
                    begin
                        px_reg     <= satp((MW+1)'(px_reg) +
                                           (MW+1)'(rnd((2*MW)'(acc_reg - MW'(mp)), 16)));
                        ma_reg     <= MW'(sd_reg);
                        mb_reg     <= dx_reg;
                        mstart_reg <= 1'b1;
                        st_reg     <= S_P3;
                    end
                S_P3:
                    if (mdone)
                    begin
                        acc_reg    <= MW'(mp);
                        ma_reg     <= MW'(cd_reg);
                        mb_reg     <= dy_reg;
                        mstart_reg <= 1'b1;
                        st_reg     <= S_P4;
                    end
                S_P4:
                    if (mdone)
                    begin
                        py_reg <= satp((MW+1)'(py_reg) +
                                       (MW+1)'(rnd((2*MW)'(acc_reg + MW'(mp)), 16)));
                        st_reg <= S_FUSE;
                    end
                S_FUSE:
                begin
                    enc_reg   <= 24'(enc_sum);
                    fused_reg <= 16'(f2);
                    st_reg    <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    st_reg        <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    logic signed [MW:0] ox, oy;
    always_comb
    begin
        ox = (MW+1)'(px_reg);
        oy = (MW+1)'(py_reg);
        out_ch.pos_x = (ox > (MW+1)'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                       (ox < -(MW+1)'(33'sh080000000)) ? 32'sh80000000 : 32'(ox);
        out_ch.pos_y = (oy > (MW+1)'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                       (oy < -(MW+1)'(33'sh080000000)) ? 32'sh80000000 : 32'(oy);
    end
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.heading      = fused_reg;
    assign out_ch.linear_speed = vd_reg;
    assign out_ch.turn_rate    = wd_reg;

    `DDO_ASSERT_IMP(a_no_accept_busy, st_reg != S_IDLE, !in_ch.ready)
    `DDO_ASSERT_NEXT(a_out_from_seq, st_reg == S_OUT, out_valid_reg)
    `DDO_ASSERT_IMP(a_head_range, out_valid_reg,
                    fused_reg <= 16'sd25723 && fused_reg >= -16'sd25723)
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Odometry core testbench
// Drives sensor and tick beats with random gaps and output back-pressure,
// predicts every pose result in bit-exact fixed point and checks each field.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic               action;
        logic signed [15:0] left_rate;
        logic signed [15:0] right_rate;
        logic signed [15:0] heading_deg;
        logic [19:0]        elapsed_us;
    } odo_beat_t;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_rate;
    } pose_t;

    localparam int POS_W = 32;
    localparam int DRAIN_CYCLES = 60;   // lets a trailing sensor beat finish after it is taken
    localparam int HOLD_CYCLES = 3000;  // long receiver hold-off

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ddo_in_if  in_ch();
    ddo_out_if out_ch();
    ddo_cfg_if cfg_ch();

    diff_drive_odometry_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always #2 clk = ~clk;

    // Pending beats, expected poses, and the shadow copy of the core's state.
    odo_beat_t beat_q[$];
    pose_t     pose_expect_q[$];
    odo_beat_t cur_beat;

    longint radius_reg;
    longint inv_track_reg;
    longint left_latch;
    longint right_latch;
    longint sens_heading;
    longint enc_heading;
    longint pos_x_acc;
    longint pos_y_acc;
    longint fused_hdg;

    int  errors = 0;
    int  ticks_done = 0;
    int  sensors_done = 0;
    int  poses_seen = 0;
    int  in_gap = 0;
    int  out_stall = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  quiet = 1'b0;

    // ---------------------------------------------------------------- predictor
    // Round half up on a right shift (arithmetic).
    function automatic longint shr_round(longint v, int s);
        longint t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Q3.13 angle in, Q.16 cosine/sine out; 16 fixed rotation steps.
    task automatic sincos(input longint ang, output longint c, output longint s);
        longint r;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        flip = 1'b0;
        r = ang % ddo_pkg::TWO_PI_Q13;
        if (r > ddo_pkg::PI_Q13) r -= ddo_pkg::TWO_PI_Q13;
        if (r < -ddo_pkg::PI_Q13) r += ddo_pkg::TWO_PI_Q13;
        // fold into +-pi/2, negate the result afterwards
        if (r > ddo_pkg::HALF_PI_Q13)
        begin
            r -= ddo_pkg::PI_Q13;
            flip = 1'b1;
        end
        else if (r < -ddo_pkg::HALF_PI_Q13)
        begin
            r += ddo_pkg::PI_Q13;
            flip = 1'b1;
        end
        x = ddo_pkg::CORDIC_GAIN;
        y = 0;
        z = r * 8;
        for (int i = 0; i < ddo_pkg::CORDIC_STEPS; i++)
        begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0)
            begin
                x -= xs;
                y += ys;
                z -= longint'(ddo_pkg::atan_q16(i[3:0]));
            end
            else
            begin
                x += xs;
                y -= ys;
                z += longint'(ddo_pkg::atan_q16(i[3:0]));
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic latch_sensor(input odo_beat_t b);
        left_latch = longint'(b.left_rate);
        right_latch = longint'(b.right_rate);
        sens_heading = clamp_bits(shr_round(longint'(b.heading_deg) * ddo_pkg::DEG2RAD_Q16,
                                            9), 16);
        sensors_done++;
    endtask

    task automatic integrate_tick(input odo_beat_t b);
        longint vd, wd, dt, step_len, dth, cd, sd, ch, sh, dx, dy, ddx, ddy, f;
        pose_t  p;
        vd = clamp_bits(shr_round(radius_reg * (left_latch + right_latch), 17), 16);
        wd = clamp_bits(shr_round(radius_reg * (left_latch - right_latch) * inv_track_reg,
                                  28), 16);
        dt = longint'(b.elapsed_us) * ddo_pkg::US_TO_S_Q40;
        step_len = shr_round(vd * dt, 32);
        dth = clamp_bits(shr_round(wd * dt, 35), 24);
        // step rotated by the turn, then by the old fused heading
        sincos(dth, cd, sd);
        dx = shr_round(cd * step_len, 16);
        dy = -shr_round(sd * step_len, 16);
        sincos(fused_hdg, ch, sh);
        ddx = shr_round(ch * dx - sh * dy, 16);
        ddy = shr_round(sh * dx + ch * dy, 16);
        pos_x_acc = clamp_bits(pos_x_acc + ddx, POS_W);
        pos_y_acc = clamp_bits(pos_y_acc + ddy, POS_W);
        enc_heading = clamp_bits(enc_heading + dth, ddo_pkg::ENC_W);
        f = (sens_heading + enc_heading) >>> 1;
        if (f >= ddo_pkg::WRAP_PI_Q13) f -= ddo_pkg::WRAP_TWO_PI_Q13;
        if (f <= -ddo_pkg::WRAP_PI_Q13) f += ddo_pkg::WRAP_TWO_PI_Q13;
        if (f > ddo_pkg::WRAP_PI_Q13) f = ddo_pkg::WRAP_PI_Q13;
        if (f < -ddo_pkg::WRAP_PI_Q13) f = -ddo_pkg::WRAP_PI_Q13;
        fused_hdg = f;
        p.pos_x = clamp_bits(pos_x_acc, 32);
        p.pos_y = clamp_bits(pos_y_acc, 32);
        p.heading = f[15:0];
        p.linear_speed = vd[15:0];
        p.turn_rate = wd[15:0];
        pose_expect_q.push_back(p);
        ticks_done++;
    endtask

    // ---------------------------------------------------------------- driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.action <= ddo_pkg::ACT_SENSOR;
            in_ch.left_rate <= '0;
            in_ch.right_rate <= '0;
            in_ch.heading_deg <= '0;
            in_ch.elapsed_us <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (cur_beat.action == ddo_pkg::ACT_TICK) integrate_tick(cur_beat);
                else latch_sensor(cur_beat);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (beat_q.size() > 0)
                begin
                    cur_beat = beat_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.action <= cur_beat.action;
                    in_ch.left_rate <= cur_beat.left_rate;
                    in_ch.right_rate <= cur_beat.right_rate;
                    in_ch.heading_deg <= cur_beat.heading_deg;
                    in_ch.elapsed_us <= cur_beat.elapsed_us;
                    if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 6);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- hold-off
    // One long hold-off so the core backs up onto its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && poses_seen >= 150)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge clk or negedge rst_n)
    begin
        pose_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                poses_seen++;
                if (pose_expect_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: pose expected none got x=%0d y=%0d", $time,
                             out_ch.pos_x, out_ch.pos_y);
                end
                else
                begin
                    e = pose_expect_q.pop_front();
                    if (out_ch.pos_x !== e.pos_x)
                    begin
                        errors++;
                        $display("%0t: pos_x expected %0d got %0d", $time, e.pos_x,
                                 out_ch.pos_x);
                    end
                    if (out_ch.pos_y !== e.pos_y)
                    begin
                        errors++;
                        $display("%0t: pos_y expected %0d got %0d", $time, e.pos_y,
                                 out_ch.pos_y);
                    end
                    if (out_ch.heading !== e.heading)
                    begin
                        errors++;
                        $display("%0t: heading expected %0d got %0d", $time, e.heading,
                                 out_ch.heading);
                    end
                    if (out_ch.linear_speed !== e.linear_speed)
                    begin
                        errors++;
                        $display("%0t: linear_speed expected %0d got %0d", $time,
                                 e.linear_speed, out_ch.linear_speed);
                    end
                    if (out_ch.turn_rate !== e.turn_rate)
                    begin
                        errors++;
                        $display("%0t: turn_rate expected %0d got %0d", $time,
                                 e.turn_rate, out_ch.turn_rate);
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) out_stall = $urandom_range(1, 6);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_beat(logic act, logic [15:0] l, logic [15:0] r, logic [15:0] h,
                            logic [19:0] et);
        odo_beat_t b;
        b.action = act;
        b.left_rate = l;
        b.right_rate = r;
        b.heading_deg = h;
        b.elapsed_us = et;
        beat_q.push_back(b);
    endtask

    function automatic logic [15:0] rand_rate();
        // mostly moderate rates so positions move without pinning
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 4096)) - 2048);
    endfunction

    function automatic logic [19:0] rand_elapsed();
        if ($urandom_range(0, 4) == 0) return 20'($urandom);
        return 20'($urandom_range(0, 100000));
    endfunction

    // Mostly sensor/tick pairs; the rest lone beats of either kind.
    task automatic add_random(int n);
        for (int i = 0; i < n; )
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                add_beat(ddo_pkg::ACT_SENSOR, rand_rate(), rand_rate(), 16'($urandom),
                         20'($urandom));
                add_beat(ddo_pkg::ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                         rand_elapsed());
                i += 2;
            end
            else
            begin
                add_beat($urandom_range(0, 1) ? ddo_pkg::ACT_TICK : ddo_pkg::ACT_SENSOR,
                         rand_rate(), rand_rate(), 16'($urandom), rand_elapsed());
                i++;
            end
        end
    endtask

    // Registers are only touched once the core has gone quiet.
    task automatic drain();
        while (beat_q.size() > 0 || in_ch.valid || pose_expect_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [ddo_pkg::IDX_W-1:0] idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == ddo_pkg::REG_WHEEL_RADIUS) radius_reg = val;
        else inv_track_reg = val;
        @(posedge clk);
    endtask

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ddo_pkg::REG_WHEEL_RADIUS;
        cfg_ch.data = '0;
        radius_reg = ddo_pkg::WHEEL_RADIUS_RST;
        inv_track_reg = ddo_pkg::INVERSE_TRACK_RST;
        left_latch = 0;
        right_latch = 0;
        sens_heading = 0;
        enc_heading = 0;
        pos_x_acc = 0;
        pos_y_acc = 0;
        fused_hdg = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults written back, field extremes, the wrap
        // around +-180 degrees, a tick on stale latches.
        write_reg(ddo_pkg::REG_WHEEL_RADIUS, ddo_pkg::WHEEL_RADIUS_RST);
        write_reg(ddo_pkg::REG_INVERSE_TRACK, ddo_pkg::INVERSE_TRACK_RST);
        add_beat(ddo_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 20'd0);
        add_beat(ddo_pkg::ACT_SENSOR, 16'h7fff, 16'h7fff, 16'h7fff, 20'hfffff);
        add_beat(ddo_pkg::ACT_TICK, 16'h8000, 16'h8000, 16'h8000, 20'hfffff);
        add_beat(ddo_pkg::ACT_SENSOR, 16'h8000, 16'h8000, 16'h8000, 20'd0);
        add_beat(ddo_pkg::ACT_TICK, 16'h7fff, 16'h7fff, 16'h7fff, 20'hfffff);
        add_beat(ddo_pkg::ACT_SENSOR, 16'h7fff, 16'h8000, 16'd11520, 20'd0);
        add_beat(ddo_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 20'hfffff);
        add_beat(ddo_pkg::ACT_TICK, 16'hffff, 16'hffff, 16'hffff, 20'd50000);
        add_beat(ddo_pkg::ACT_SENSOR, 16'h8000, 16'h7fff, -16'sd11520, 20'hfffff);
        add_beat(ddo_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 20'hfffff);
        add_beat(ddo_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 20'hfffff);
        add_beat(ddo_pkg::ACT_SENSOR, 16'h0100, 16'hff00, 16'd11500, 20'd0);
        add_beat(ddo_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 20'd1);
        add_beat(ddo_pkg::ACT_SENSOR, 16'h0400, 16'h0400, 16'h0000, 20'd0);
        add_beat(ddo_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 20'd100000);
        add_beat(ddo_pkg::ACT_SENSOR, 16'h0000, 16'h0000, 16'h0000, 20'd0);
        add_beat(ddo_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 20'hfffff);
        add_random(280);
        drain();

        // Largest radius and inverse track: speeds saturate, heading wraps.
        write_reg(ddo_pkg::REG_WHEEL_RADIUS, 16'hffff);
        write_reg(ddo_pkg::REG_INVERSE_TRACK, 16'hffff);
        add_random(250);
        drain();

        // Smallest values: speeds mostly round to zero.
        write_reg(ddo_pkg::REG_WHEEL_RADIUS, 16'd1);
        write_reg(ddo_pkg::REG_INVERSE_TRACK, 16'd1);
        add_random(200);
        drain();

        write_reg(ddo_pkg::REG_WHEEL_RADIUS, 16'($urandom_range(1, 65535)));
        write_reg(ddo_pkg::REG_INVERSE_TRACK, 16'($urandom_range(1, 65535)));
        add_random(250);
        drain();

        // Back to defaults, no idling on either side.
        write_reg(ddo_pkg::REG_WHEEL_RADIUS, ddo_pkg::WHEEL_RADIUS_RST);
        write_reg(ddo_pkg::REG_INVERSE_TRACK, ddo_pkg::INVERSE_TRACK_RST);
        quiet = 1'b1;
        add_random(200);
        drain();

        $display("Covered %0d tick and %0d sensor beats, %0d poses checked,", ticks_done,
                 sensors_done, poses_seen);
        $display("over five register settings with random gaps and one long hold-off.");
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: fails the run if it has not finished within the time limit below.
    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ diff_drive_odometry_core.f @@
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_if.sv
rtl/ddo_serial_mul.sv
rtl/ddo_cordic.sv
rtl/diff_drive_odometry_core.sv
bench/tb_top.sv
